// File: rtl/oqc_pkg.sv
`timescale 1ns / 1ps

package oqc_pkg;

	localparam int CAPACITY   = 1024;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int ID_W       = 32;
	localparam int WORD_W     = ID_W + 1;
	localparam int OP_W       = 2;
	localparam int STAT_W     = 2;
	localparam int OUT_DATA_W = ((ID_W + CNT_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - ID_W - CNT_W;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_POP    = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_DAT,
		S_SCAN,
		S_RECL,
		S_RESP
	} state_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   out_id;
		logic [CNT_W-1:0]  entries_left;
	} result_t;

	function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] s);
		logic [ADDR_W-1:0] r;
		if (s == ADDR_W'(CAPACITY - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

endpackage

// File: rtl/ordered_queue_with_cancel.sv
`timescale 1ns / 1ps
// Append, no-op and rejected requests go from idle straight to the response state; pop reads
// the head item, clears its slot and reclaims the dead slots behind it; remove scans from the
// head, and when the head itself is removed it also reclaims the dead slots behind it.
// One item in flight: the single read port walks one slot per cycle during a scan or reclaim;
// the next transaction enters once its result is registered.
// Reset: asynchronous, clears pointers, counters and valid output; slot memory is not cleared.

module ordered_queue_with_cancel
	import oqc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [ID_W-1:0]       s_axis_tdata,  // [31:0] item_id
	input  logic [OP_W-1:0]       s_axis_tuser,  // [1:0] opcode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] out_id, [42:32] entries_left, zero pad
	output logic [STAT_W-1:0]     m_axis_tuser   // [1:0] status
);

	logic              res_valid;
	logic              res_ready;
	result_t           res;
	result_t           out_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	oqc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (opcode_t'(s_axis_tuser)),
		.in_id     (s_axis_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	oqc_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_W)
	) u_ram (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// load the output register when empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.entries_left, out_q.out_id};

endmodule

// File: rtl/oqc_ram.sv
`timescale 1ns / 1ps

module oqc_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 33
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/oqc_ctrl.sv
`timescale 1ns / 1ps

module oqc_ctrl
	import oqc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  opcode_t           in_op,
	input  logic [ID_W-1:0]   in_id,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [WORD_W-1:0] rd_data,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [WORD_W-1:0] wr_data
);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] head_q, head_d;
	logic [ADDR_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0]  used_q, used_d;
	logic [CNT_W-1:0]  live_q, live_d;
	logic [ID_W-1:0]   key_q, key_d;
	logic [ADDR_W-1:0] sp_q, sp_d;
	logic [ADDR_W-1:0] rptr_q, rptr_d;
	logic [CNT_W-1:0]  remain_q, remain_d;
	logic              pend_q, pend_d;
	status_t           status_q, status_d;
	logic [ID_W-1:0]   popped_q, popped_d;
	logic              rd_live;
	logic [ID_W-1:0]   rd_id;

	assign rd_live = rd_data[WORD_W-1];
	assign rd_id   = rd_data[ID_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			used_q  <= '0;
			live_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			used_q  <= used_d;
			live_q  <= live_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q    <= key_d;
		sp_q     <= sp_d;
		rptr_q   <= rptr_d;
		remain_q <= remain_d;
		status_q <= status_d;
		popped_q <= popped_d;
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		used_d    = used_q;
		live_d    = live_q;
		key_d     = key_q;
		sp_d      = sp_q;
		rptr_d    = rptr_q;
		remain_d  = remain_q;
		pend_d    = pend_q;
		status_d  = status_q;
		popped_d  = popped_q;
		rd_addr   = head_q;
		wr_en     = 1'b0;
		wr_addr   = tail_q;
		wr_data   = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					key_d    = in_id;
					popped_d = '0;
					status_d = ST_OK;
					state_d  = S_RESP;
					case (in_op)
						OP_APPEND: begin
							if (used_q == CNT_W'(CAPACITY)) begin
								status_d = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = tail_q;
								wr_data = {1'b1, in_id};
								tail_d  = slot_inc(tail_q);
								used_d  = used_q + 1'b1;
								live_d  = live_q + 1'b1;
							end
						end
						OP_REMOVE: begin
							if (used_q == '0) begin
								status_d = ST_NOT_FOUND;
							end else begin
								// read of the head slot goes out this cycle
								sp_d     = head_q;
								remain_d = used_q;
								rptr_d   = slot_inc(head_q);
								pend_d   = 1'b1;
								state_d  = S_SCAN;
							end
						end
						OP_POP: begin
							if (live_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_POP_DAT;
							end
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end

			S_POP_DAT: begin
				popped_d = rd_id;
				wr_en    = 1'b1;
				wr_addr  = head_q;
				wr_data  = '0;
				live_d   = live_q - 1'b1;
				head_d   = slot_inc(head_q);
				used_d   = used_q - 1'b1;
				rptr_d   = slot_inc(head_q);
				pend_d   = 1'b0;
				state_d  = S_RECL;
			end

			S_SCAN: begin
				rd_addr = rptr_q;
				rptr_d  = slot_inc(rptr_q);
				pend_d  = 1'b1;
				if (rd_live && (rd_id == key_q)) begin
					wr_en   = 1'b1;
					wr_addr = sp_q;
					wr_data = '0;
					live_d  = live_q - 1'b1;
					if (sp_q == head_q) begin
						// head removed: advance and reclaim the dead slots behind it
						head_d  = slot_inc(head_q);
						used_d  = used_q - 1'b1;
						rptr_d  = slot_inc(head_q);
						pend_d  = 1'b0;
						state_d = S_RECL;
					end else begin
						state_d = S_RESP;
					end
				end else begin
					sp_d     = slot_inc(sp_q);
					remain_d = remain_q - 1'b1;
					if (remain_q == CNT_W'(1)) begin
						status_d = ST_NOT_FOUND;
						state_d  = S_RESP;
					end
				end
			end

			S_RECL: begin
				// read data belongs to the current head slot whenever pend_q is set
				rd_addr = rptr_q;
				rptr_d  = slot_inc(rptr_q);
				pend_d  = 1'b1;
				if (used_q == '0) begin
					tail_d  = head_q;
					state_d = S_RESP;
				end else if (pend_q) begin
					if (rd_live) begin
						state_d = S_RESP;
					end else begin
						head_d = slot_inc(head_q);
						used_d = used_q - 1'b1;
						if (used_q == CNT_W'(1)) begin
							tail_d  = slot_inc(head_q);
							state_d = S_RESP;
						end
					end
				end
			end

			S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res.status       = status_q;
	assign res.out_id       = popped_q;
	assign res.entries_left = live_q;

endmodule

// File: rtl/oqc_checker.sv
`timescale 1ns / 1ps

module oqc_checker
	import oqc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [STAT_W-1:0]     m_axis_tuser
);

	logic [ID_W-1:0]  out_id;
	logic [CNT_W-1:0] entries_left;

	assign out_id       = m_axis_tdata[ID_W-1:0];
	assign entries_left = m_axis_tdata[ID_W+CNT_W-1:ID_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("transaction accepted while previous one in progress");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> (entries_left == '0))
		else $error("empty status with live entries");

	a_fail_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (out_id == '0))
		else $error("nonzero identifier on failed request");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (entries_left <= CNT_W'(CAPACITY)))
		else $error("entry count beyond capacity");

endmodule

bind ordered_queue_with_cancel oqc_checker u_oqc_checker (.*);
